// ===== rtl/rtgo_pkg.sv =====
// ----------------------------------------------------------------------------
// rtgo_pkg
// shared types and constants for the rectangle versus tile grid overlap block
// ----------------------------------------------------------------------------
`default_nettype none

package rtgo_pkg;

    localparam int COORD_W = 17;
    localparam int SIZE_W  = 16;
    localparam int CS_W    = 8;
    localparam int DIM_W   = 7;
    localparam int IDX_W   = 6;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int OPND_W  = 20;
    localparam int QUO_W   = 16;
    localparam int REM_W   = 9;
    localparam int STEP_W  = 4;
    localparam int NUM_OPND = 4;
    localparam int OPND_IDX_W = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_SIDE_UNITS = 3'd2;
    localparam logic [2:0] REG_GRID_COLS = 3'd3;
    localparam logic [2:0] REG_GRID_ROWS = 3'd4;

    localparam logic [CS_W-1:0]  SIDE_UNITS_RST = 8'd16;
    localparam logic [DIM_W-1:0] GRID_DIM_RST  = 7'd64;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [CS_W-1:0]           side_units;
        logic [DIM_W-1:0]          grid_cols;
        logic [DIM_W-1:0]          grid_rows;
    } cfg_t;

    typedef struct packed {
        logic clr_en;
        logic cell_wr;
        logic query_start;
        logic div_load;
        logic div_step;
        logic range_load;
        logic scan_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic opnd_last;
        logic empty;
        logic scan_last;
        logic hit_now;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/rtgo_if.sv =====
// ----------------------------------------------------------------------------
// rtgo_if
// request and result channels with valid and ready
// ----------------------------------------------------------------------------
`default_nettype none

interface rtgo_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [5:0]         cell_col;
    logic [5:0]         cell_row;
    logic               solid_bit;
    logic signed [16:0] rect_x;
    logic signed [16:0] rect_y;
    logic [15:0]        rect_width;
    logic [15:0]        rect_height;

    modport source (
        output valid, op, cell_col, cell_row, solid_bit,
        output rect_x, rect_y, rect_width, rect_height,
        input  ready
    );
    modport sink (
        input  valid, op, cell_col, cell_row, solid_bit,
        input  rect_x, rect_y, rect_width, rect_height,
        output ready
    );
endinterface

interface rtgo_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

// ===== rtl/rtgo_cfg.sv =====
// ----------------------------------------------------------------------------
// rtgo_cfg
// configuration register file behind the apb port
// ----------------------------------------------------------------------------
`default_nettype none

module rtgo_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rtgo_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rtgo_pkg::DATA_W-1:0] pwdata,
    output logic      [rtgo_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output rtgo_pkg::cfg_t                   cfg
);
    import rtgo_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ORIGIN_X:   cfg_next.origin_x   = $signed(pwdata[COORD_W-1:0]);
                REG_ORIGIN_Y:   cfg_next.origin_y   = $signed(pwdata[COORD_W-1:0]);
                REG_SIDE_UNITS: cfg_next.side_units = pwdata[CS_W-1:0];
                REG_GRID_COLS:  cfg_next.grid_cols  = pwdata[DIM_W-1:0];
                REG_GRID_ROWS:  cfg_next.grid_rows  = pwdata[DIM_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ORIGIN_X:   prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_reg.origin_x};
            REG_ORIGIN_Y:   prdata = {{(DATA_W-COORD_W){1'b0}}, cfg_reg.origin_y};
            REG_SIDE_UNITS: prdata = {{(DATA_W-CS_W){1'b0}}, cfg_reg.side_units};
            REG_GRID_COLS:  prdata = {{(DATA_W-DIM_W){1'b0}}, cfg_reg.grid_cols};
            REG_GRID_ROWS:  prdata = {{(DATA_W-DIM_W){1'b0}}, cfg_reg.grid_rows};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x   <= '0;
            cfg_reg.origin_y   <= '0;
            cfg_reg.side_units <= SIDE_UNITS_RST;
            cfg_reg.grid_cols  <= GRID_DIM_RST;
            cfg_reg.grid_rows  <= GRID_DIM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rtgo_dp.sv =====
// ----------------------------------------------------------------------------
// rtgo_dp
// datapath: solid cell memory, serial divider, range clip and cell scan
// ----------------------------------------------------------------------------
`default_nettype none

module rtgo_dp #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  rtgo_pkg::cfg_t                    cfg,
    input  rtgo_pkg::cmd_t                    cmd,
    output rtgo_pkg::sts_t                    sts,
    input  wire logic [rtgo_pkg::IDX_W-1:0]   cell_col,
    input  wire logic [rtgo_pkg::IDX_W-1:0]   cell_row,
    input  wire logic                         solid_bit,
    input  wire logic signed [rtgo_pkg::COORD_W-1:0] rect_x,
    input  wire logic signed [rtgo_pkg::COORD_W-1:0] rect_y,
    input  wire logic [rtgo_pkg::SIZE_W-1:0]  rect_width,
    input  wire logic [rtgo_pkg::SIZE_W-1:0]  rect_height,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic                              out_hit
);
    import rtgo_pkg::*;

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;

    logic mem [DEPTH];
    logic mem_q_reg;
    logic rd_v_reg;

    logic [AW-1:0] clr_cnt_reg;

    logic signed [COORD_W-1:0] left_reg;
    logic signed [COORD_W-1:0] top_reg;
    logic [SIZE_W-1:0]         width_reg;
    logic [SIZE_W-1:0]         height_reg;

    logic [OPND_IDX_W-1:0] opnd_idx_reg;
    logic [STEP_W-1:0]     step_cnt_reg;
    logic [QUO_W-1:0]      dq_reg;
    logic [REM_W-1:0]      dr_reg;
    logic [QUO_W-1:0]      quo_reg [NUM_OPND];
    logic                  neg_reg [NUM_OPND];

    logic [CW-1:0] cmin_reg, cmax_reg, col_reg;
    logic [RW-1:0] rmin_reg, rmax_reg, row_reg;
    logic          hit_reg;
    logic          out_valid_reg;
    logic          out_hit_reg;

    logic signed [OPND_W-1:0] opnd;
    logic [REM_W-1:0]         rem_sh;
    logic                     ge;
    logic [REM_W-1:0]         dr_next;
    logic [QUO_W-1:0]         dq_next;

    logic [QUO_W-1:0] cols_eff, rows_eff;
    logic [QUO_W-1:0] cmin16, cmax16, rmin16, rmax16;
    logic             col_empty, row_empty;
    logic [AW-1:0]    wr_addr;
    logic             wr_ok;
    logic             col_end;

    always_comb
    begin
        case (opnd_idx_reg)
            2'd0:    opnd = OPND_W'(left_reg) - OPND_W'(cfg.origin_x);
            2'd1:    opnd = OPND_W'(left_reg) + $signed(OPND_W'(width_reg))
                            - OPND_W'(cfg.origin_x) - 20'sd1;
            2'd2:    opnd = OPND_W'(top_reg) - OPND_W'(cfg.origin_y);
            default: opnd = OPND_W'(top_reg) + $signed(OPND_W'(height_reg))
                            - OPND_W'(cfg.origin_y) - 20'sd1;
        endcase
    end

    // restoring division of the whole-unit offset by the cell size
    assign rem_sh  = {dr_reg[REM_W-2:0], dq_reg[QUO_W-1]};
    assign ge      = rem_sh >= {1'b0, cfg.side_units};
    assign dr_next = ge ? (rem_sh - {1'b0, cfg.side_units}) : rem_sh;
    assign dq_next = {dq_reg[QUO_W-2:0], ge};

    assign cols_eff = (32'(cfg.grid_cols) > MAX_COLS) ? QUO_W'(MAX_COLS)
                                                      : QUO_W'(cfg.grid_cols);
    assign rows_eff = (32'(cfg.grid_rows) > MAX_ROWS) ? QUO_W'(MAX_ROWS)
                                                      : QUO_W'(cfg.grid_rows);

    always_comb
    begin
        cmin16 = neg_reg[0] ? '0 : quo_reg[0];
        cmax16 = (quo_reg[1] > cols_eff - 1'b1) ? cols_eff - 1'b1 : quo_reg[1];
        rmin16 = neg_reg[2] ? '0 : quo_reg[2];
        rmax16 = (quo_reg[3] > rows_eff - 1'b1) ? rows_eff - 1'b1 : quo_reg[3];
        col_empty = (cols_eff == '0) || neg_reg[1]
                    || (!neg_reg[0] && quo_reg[0] >= cols_eff) || (cmin16 > cmax16);
        row_empty = (rows_eff == '0) || neg_reg[3]
                    || (!neg_reg[2] && quo_reg[2] >= rows_eff) || (rmin16 > rmax16);
    end

    assign wr_addr = {RW'(cell_row), CW'(cell_col)};
    assign wr_ok   = (32'(cell_col) < MAX_COLS) && (32'(cell_row) < MAX_ROWS);
    assign col_end = (col_reg == cmax_reg);

    assign sts.clr_last  = &clr_cnt_reg;
    assign sts.div_last  = &step_cnt_reg;
    assign sts.opnd_last = &opnd_idx_reg;
    assign sts.empty     = (cfg.side_units == '0) || col_empty || row_empty;
    assign sts.scan_last = col_end && (row_reg == rmax_reg);
    assign sts.hit_now   = rd_v_reg && mem_q_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            mem[clr_cnt_reg] <= 1'b0;
        end
        else if (cmd.cell_wr && wr_ok)
        begin
            mem[wr_addr] <= solid_bit;
        end
        if (cmd.scan_rd)
        begin
            mem_q_reg <= mem[{row_reg, col_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            left_reg   <= rect_x;
            top_reg    <= rect_y;
            width_reg  <= rect_width;
            height_reg <= rect_height;
        end
        if (cmd.div_load)
        begin
            dq_reg                <= opnd[OPND_W-1:OPND_W-QUO_W];
            dr_reg                <= '0;
            neg_reg[opnd_idx_reg] <= opnd[OPND_W-1];
        end
        else if (cmd.div_step)
        begin
            dq_reg <= dq_next;
            dr_reg <= dr_next;
            if (&step_cnt_reg)
            begin
                quo_reg[opnd_idx_reg] <= dq_next;
            end
        end
        if (cmd.range_load)
        begin
            cmin_reg <= cmin16[CW-1:0];
            cmax_reg <= cmax16[CW-1:0];
            rmin_reg <= rmin16[RW-1:0];
            rmax_reg <= rmax16[RW-1:0];
        end
        if (cmd.range_load)
        begin
            col_reg <= cmin16[CW-1:0];
            row_reg <= rmin16[RW-1:0];
        end
        else if (cmd.scan_rd)
        begin
            if (col_end)
            begin
                col_reg <= cmin_reg;
                row_reg <= row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            out_hit_reg <= hit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            rd_v_reg      <= 1'b0;
            opnd_idx_reg  <= '0;
            step_cnt_reg  <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            rd_v_reg <= cmd.scan_rd;
            if (cmd.query_start)
            begin
                opnd_idx_reg <= '0;
            end
            else if (cmd.div_step && (&step_cnt_reg))
            begin
                opnd_idx_reg <= opnd_idx_reg + 1'b1;
            end
            if (cmd.div_load)
            begin
                step_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end
            if (cmd.query_start)
            begin
                hit_reg <= 1'b0;
            end
            else if (sts.hit_now)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> (col_reg <= cmax_reg) && (row_reg <= rmax_reg))
        else $error("scan address outside clipped range");

    a_hit_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg && !cmd.query_start |=> hit_reg)
        else $error("hit flag dropped during a query");

    a_no_wr_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> !cmd.cell_wr && !cmd.clr_en)
        else $error("memory write during scan");

endmodule

`default_nettype wire

// ===== rtl/rtgo_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtgo_ctrl
// controller: clearing pass, request accept, divide, scan and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module rtgo_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_op,
    output logic               in_ready,
    input  rtgo_pkg::sts_t     sts,
    output rtgo_pkg::cmd_t     cmd
);
    import rtgo_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DLOAD  = 8'b0000_0100,
        S_DSTEP  = 8'b0000_1000,
        S_CHECK  = 8'b0001_0000,
        S_SCAN   = 8'b0010_0000,
        S_DRAIN  = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_op == OP_QUERY)
                    begin
                        cmd.query_start = 1'b1;
                        state_next      = S_DLOAD;
                    end
                    else
                    begin
                        cmd.cell_wr = 1'b1;
                    end
                end
            end
            S_DLOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = sts.opnd_last ? S_CHECK : S_DLOAD;
                end
            end
            S_CHECK:
            begin
                cmd.range_load = 1'b1;
                state_next     = sts.empty ? S_RESULT : S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.hit_now)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending result");

    a_query_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (in_op == OP_QUERY) |=> state_reg == S_DLOAD)
        else $error("query request did not start the divider");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_en |-> !in_ready)
        else $error("request accepted during clearing pass");

endmodule

`default_nettype wire

// ===== rtl/rect_tile_grid_overlap_top.sv =====
// ----------------------------------------------------------------------------
// rect_tile_grid_overlap_top
// rectangle versus tile grid solid cell overlap test
// ----------------------------------------------------------------------------
// After reset the block clears its solid cell memory, one cell per cycle,
// over all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells (4096 by default),
// and accepts no request in that time. A write request is written as it is
// accepted. A query request runs four floor divisions on one shared
// bit-serial divider, then a clip step, then reads the memory one cell per
// cycle over the clipped column and row range until the first solid cell,
// then hands off the result; an empty range skips the scan. One result
// is buffered, so the next request is taken while a result waits.
`default_nettype none

module rect_tile_grid_overlap_top #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rtgo_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rtgo_pkg::DATA_W-1:0] pwdata,
    output logic      [rtgo_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    rtgo_in_if.sink                          in_ch,
    rtgo_out_if.source                       out_ch
);
    import rtgo_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    rtgo_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rtgo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (in_ch.op),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rtgo_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .sts         (sts),
        .cell_col    (in_ch.cell_col),
        .cell_row    (in_ch.cell_row),
        .solid_bit   (in_ch.solid_bit),
        .rect_x      (in_ch.rect_x),
        .rect_y      (in_ch.rect_y),
        .rect_width  (in_ch.rect_width),
        .rect_height (in_ch.rect_height),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_hit     (out_ch.hit)
    );

endmodule

`default_nettype wire
